// File: hw/rtl/mldc_pkg.sv
// Package for the motion light and door controller.
// Holds the field widths, operation and door-state codes, item types and period helpers.
// No dependencies; every other file of the block imports it.
package mldc_pkg;

    localparam int TIMEOUT_W = 16;
    localparam int MOTION_W  = 26;
    localparam int HOLD_W    = 30;
    localparam int PULSE_W   = 9;

    localparam int unsigned MS_PER_SECOND = 1000;
    localparam int unsigned HOLD_FACTOR   = 10;

    localparam logic [PULSE_W-1:0]   PULSE_TICKS   = PULSE_W'(500);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(60);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_MOTION = 2'd1,
        OP_LIGHT  = 2'd2,
        OP_DOOR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DOOR_CLOSED  = 2'd0,
        DOOR_OPEN    = 2'd1,
        DOOR_BETWEEN = 2'd2
    } door_state_t;

    typedef struct packed {
        op_t  op;
        logic motion_level;
        logic open_sense;
        logic reed_closed;
    } item_t;

    typedef struct packed {
        logic        light_on;
        logic        override_on;
        logic        door_drive;
        door_state_t door_state;
    } result_t;

    typedef struct packed {
        logic [MOTION_W-1:0] motion;
        logic [HOLD_W-1:0]   hold;
    } periods_t;

    function automatic logic [MOTION_W-1:0] motion_period(input logic [TIMEOUT_W-1:0] secs);
        logic [TIMEOUT_W-1:0] eff;
        eff = (secs == '0) ? TIMEOUT_W'(1) : secs;
        return MOTION_W'(MOTION_W'(eff) * MOTION_W'(MS_PER_SECOND));
    endfunction

    function automatic logic [HOLD_W-1:0] hold_period(input logic [TIMEOUT_W-1:0] secs);
        logic [TIMEOUT_W-1:0] eff;
        eff = (secs == '0) ? TIMEOUT_W'(1) : secs;
        return HOLD_W'(HOLD_W'(eff) * HOLD_W'(MS_PER_SECOND * HOLD_FACTOR));
    endfunction

endpackage

// File: hw/rtl/mldc_if.sv
// Channel interfaces for the motion light and door controller.
// Event input, status output and timeout configuration channels; depends on mldc_pkg.
interface mldc_event_if;
    import mldc_pkg::*;
    logic valid;
    logic ready;
    op_t  op;
    logic motion_level;
    logic open_sense;
    logic reed_closed;
    modport source (output valid, op, motion_level, open_sense, reed_closed, input ready);
    modport sink (input valid, op, motion_level, open_sense, reed_closed, output ready);
endinterface

interface mldc_status_if;
    import mldc_pkg::*;
    logic        valid;
    logic        ready;
    logic        light_on;
    logic        override_on;
    logic        door_drive;
    door_state_t door_state;
    modport source (output valid, light_on, override_on, door_drive, door_state, input ready);
    modport sink (input valid, light_on, override_on, door_drive, door_state, output ready);
endinterface

interface mldc_cfg_if;
    import mldc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TIMEOUT_W-1:0] light_timeout_seconds;
    modport source (output valid, light_timeout_seconds, input ready);
    modport sink (input valid, light_timeout_seconds, output ready);
endinterface

// File: hw/rtl/motion_light_door_controller.sv
// Top level of the motion light and door controller.
// Input register, result register and the instances of mldc_cfg and mldc_core.
// Depends on mldc_pkg and the interfaces in mldc_if.
//
// Each transfer on the events channel is a one millisecond tick, a motion rising
// edge, a light button press or a door button press, together with the live
// motion and reed levels. Each one yields exactly one transfer on the status
// channel with the light, override and door drive levels after the event and
// the door position decoded from the reeds.
// An event is registered at the input, applied to the timers when it leaves the
// input register, and its status is then held in the output register.
// One event is accepted every cycle while the receiver keeps up.
// When the receiver stalls, the output register holds its status and one more
// event is still taken into the input register before events.ready drops.
// The cfg channel is always ready and sets the light timeout in seconds; the
// override lasts ten times as long and a timeout of zero counts as one second.
// Reset turns the light, override and door drive off, stops both timers and
// sets the timeout to sixty seconds.
module motion_light_door_controller (
    input  logic          clk,
    input  logic          rst_n,
    mldc_event_if.sink    events,
    mldc_status_if.source status,
    mldc_cfg_if.sink      cfg
);
    import mldc_pkg::*;

    logic     s1_valid_reg, s1_valid_next;
    item_t    s1_item_reg;
    logic     out_valid_reg, out_valid_next;
    result_t  result_reg;
    result_t  result;
    periods_t periods;
    logic     s1_advance;
    logic     in_transfer;

    assign s1_advance   = s1_valid_reg && (!out_valid_reg || status.ready);
    assign events.ready = !s1_valid_reg || s1_advance;
    assign in_transfer  = events.valid && events.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_transfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            s1_item_reg.op           <= events.op;
            s1_item_reg.motion_level <= events.motion_level;
            s1_item_reg.open_sense   <= events.open_sense;
            s1_item_reg.reed_closed  <= events.reed_closed;
        end
        if (s1_advance)
        begin
            result_reg <= result;
        end
    end

    mldc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .periods (periods)
    );

    mldc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_advance),
        .item    (s1_item_reg),
        .periods (periods),
        .result  (result)
    );

    assign status.valid       = out_valid_reg;
    assign status.light_on    = result_reg.light_on;
    assign status.override_on = result_reg.override_on;
    assign status.door_drive  = result_reg.door_drive;
    assign status.door_state  = result_reg.door_state;

`ifndef SYNTH
    a_ready_low_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        !events.ready |-> s1_valid_reg)
        else $error("Events are refused while the input register is empty.");

    a_advance_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> status.valid)
        else $error("An applied event did not produce a pending status.");

    a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("An event in the input register was lost during a stall.");

    a_periods_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (periods.motion != '0) && (periods.hold != '0))
        else $error("A timer period is zero.");
`endif

endmodule

// File: hw/rtl/mldc_cfg.sv
// Timeout configuration register of the motion light and door controller.
// Turns a written timeout in seconds into motion and override periods in ticks.
// Depends on mldc_pkg and mldc_cfg_if.
module mldc_cfg (
    input  logic              clk,
    input  logic              rst_n,
    mldc_cfg_if.sink          cfg,
    output mldc_pkg::periods_t periods
);
    import mldc_pkg::*;

    periods_t periods_reg;
    periods_t periods_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        periods_next = periods_reg;
        if (cfg.valid)
        begin
            periods_next.motion = motion_period(cfg.light_timeout_seconds);
            periods_next.hold   = hold_period(cfg.light_timeout_seconds);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periods_reg.motion <= motion_period(TIMEOUT_RESET);
            periods_reg.hold   <= hold_period(TIMEOUT_RESET);
        end
        else
        begin
            periods_reg <= periods_next;
        end
    end

    assign periods = periods_reg;

endmodule

// File: hw/rtl/mldc_core.sv
// Light, override and door pulse state of the motion light and door controller.
// Applies one item per step and presents the resulting status; depends on mldc_pkg.
module mldc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  mldc_pkg::item_t    item,
    input  mldc_pkg::periods_t periods,
    output mldc_pkg::result_t  result
);
    import mldc_pkg::*;

    logic                light_reg, light_next;
    logic                override_reg, override_next;
    logic [MOTION_W-1:0] motion_count_reg, motion_count_next;
    logic                motion_running_reg, motion_running_next;
    logic [HOLD_W-1:0]   hold_count_reg, hold_count_next;
    logic                hold_running_reg, hold_running_next;
    logic [PULSE_W-1:0]  pulse_count_reg, pulse_count_next;
    logic                pulse_level_reg, pulse_level_next;

    logic [MOTION_W-1:0] motion_dec;
    logic [HOLD_W-1:0]   hold_dec;
    logic [PULSE_W-1:0]  pulse_dec;
    logic                motion_exp;
    logic                hold_exp;
    door_state_t         door_state;

    assign motion_dec = (motion_count_reg != '0) ? motion_count_reg - 1'b1 : '0;
    assign hold_dec   = (hold_count_reg != '0) ? hold_count_reg - 1'b1 : '0;
    assign pulse_dec  = (pulse_count_reg != '0) ? pulse_count_reg - 1'b1 : '0;
    assign motion_exp = motion_running_reg && (motion_dec == '0);
    assign hold_exp   = hold_running_reg && (hold_dec == '0);

    always_comb
    begin
        light_next          = light_reg;
        override_next       = override_reg;
        motion_count_next   = motion_count_reg;
        motion_running_next = motion_running_reg;
        hold_count_next     = hold_count_reg;
        hold_running_next   = hold_running_reg;
        pulse_count_next    = pulse_count_reg;
        pulse_level_next    = pulse_level_reg;
        case (item.op)
            OP_TICK:
            begin
                if (motion_running_reg)
                begin
                    motion_count_next   = motion_dec;
                    motion_running_next = !motion_exp;
                end
                if (hold_running_reg)
                begin
                    hold_count_next   = hold_dec;
                    hold_running_next = !hold_exp;
                end
                if (pulse_level_reg)
                begin
                    pulse_count_next = pulse_dec;
                    pulse_level_next = (pulse_dec != '0);
                end
                if (motion_exp || hold_exp)
                begin
                    if (item.motion_level)
                    begin
                        motion_count_next   = periods.motion;
                        motion_running_next = 1'b1;
                    end
                    else if (hold_exp || !override_reg)
                    begin
                        light_next = 1'b0;
                    end
                end
                if (hold_exp)
                begin
                    override_next = 1'b0;
                end
            end
            OP_MOTION:
            begin
                light_next          = 1'b1;
                motion_count_next   = periods.motion;
                motion_running_next = 1'b1;
            end
            OP_LIGHT:
            begin
                override_next     = 1'b1;
                light_next        = !light_reg;
                hold_count_next   = periods.hold;
                hold_running_next = 1'b1;
            end
            default:
            begin
                pulse_level_next = 1'b1;
                pulse_count_next = PULSE_TICKS;
            end
        endcase
    end

    always_comb
    begin
        if (item.open_sense)
        begin
            door_state = DOOR_OPEN;
        end
        else if (item.reed_closed)
        begin
            door_state = DOOR_CLOSED;
        end
        else
        begin
            door_state = DOOR_BETWEEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg          <= 1'b0;
            override_reg       <= 1'b0;
            motion_count_reg   <= '0;
            motion_running_reg <= 1'b0;
            hold_count_reg     <= '0;
            hold_running_reg   <= 1'b0;
            pulse_count_reg    <= '0;
            pulse_level_reg    <= 1'b0;
        end
        else if (step)
        begin
            light_reg          <= light_next;
            override_reg       <= override_next;
            motion_count_reg   <= motion_count_next;
            motion_running_reg <= motion_running_next;
            hold_count_reg     <= hold_count_next;
            hold_running_reg   <= hold_running_next;
            pulse_count_reg    <= pulse_count_next;
            pulse_level_reg    <= pulse_level_next;
        end
    end

    assign result.light_on    = light_next;
    assign result.override_on = override_next;
    assign result.door_drive  = pulse_level_next;
    assign result.door_state  = door_state;

endmodule
